FILE: src/hhg_pkg.sv
package hhg_pkg;

  // Fixed-point format shared by all quantities
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;

  // Datapath widths
  localparam int R2_W    = 2 * DATA_W;                 // sum of squares
  localparam int ROOT_W  = DATA_W;                     // r
  localparam int REM_W   = ROOT_W + 2;                 // square root remainder
  localparam int S_W     = DATA_W + 1;                 // s = r + a
  localparam int S2_W    = 2 * S_W;                    // s*s
  localparam int GM_W    = 2 * DATA_W;                 // G*M
  localparam int DEN_W   = S2_W + ROOT_W;              // s*s*r
  localparam int PROD_W  = GM_W + DATA_W;              // G*M*|pos|
  localparam int NUM_W   = PROD_W + FRAC_BITS;         // shifted numerator
  localparam int Q_W     = 35;                         // quotient bits kept
  localparam int ACC_P_W = DEN_W + 1 + Q_W;            // divider shift register
  localparam int POT_P_W = S_W + 1 + Q_W;

  localparam int SQ_STAGES  = ROOT_W;
  localparam int DIV_STAGES = Q_W;

  // Clamp limits on quotients
  localparam logic [Q_W-1:0] ACC_Q_MAX = Q_W'(64'd1 << 34);
  localparam logic [Q_W-1:0] POT_Q_MAX = Q_W'(64'd1 << 31);

  // Register indexes
  localparam logic [1:0] REG_HALO_MASS    = 2'd0;
  localparam logic [1:0] REG_SCALE_LENGTH = 2'd1;
  localparam logic [1:0] REG_GRAV_CONST   = 2'd2;

  localparam logic [DATA_W-1:0] CFG_RESET = 32'd65536;

  typedef struct packed {
    logic [DATA_W-1:0] halo_mass;
    logic [DATA_W-1:0] scale_length;
    logic [DATA_W-1:0] grav_const;
  } cfg_t;

  // Payload that rides along the square root pipeline
  typedef struct packed {
    logic [2:0][DATA_W-1:0] acc;
    logic [2:0][DATA_W-1:0] mag;
    logic [2:0]             pos_pos;
    logic [2:0]             pos_neg;
  } sq_side_t;

  typedef struct packed {
    logic [R2_W-1:0]   rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    sq_side_t          side;
  } sq_data_t;

  // Payload that rides along the divider pipeline
  typedef struct packed {
    logic [2:0][DATA_W-1:0] acc;
    logic [2:0]             pos_pos;
    logic [2:0]             pos_neg;
    logic                   r_nz;
    logic                   s_z;
    logic [2:0]             ovf;
    logic                   pot_ovf;
  } dv_side_t;

  typedef struct packed {
    logic [2:0][ACC_P_W-1:0] p;
    logic [DEN_W-1:0]        den;
    logic [POT_P_W-1:0]      pp;
    logic [S_W-1:0]          s;
    dv_side_t                side;
  } dv_data_t;

endpackage

FILE: src/hhg_apb_regs.sv
module hhg_apb_regs import hhg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q;
  logic [1:0] idx;
  logic       wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register writes; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.halo_mass    <= CFG_RESET;
      cfg_q.scale_length <= CFG_RESET;
      cfg_q.grav_const   <= CFG_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_HALO_MASS:    cfg_q.halo_mass    <= pwdata;
        REG_SCALE_LENGTH: cfg_q.scale_length <= pwdata;
        REG_GRAV_CONST:   cfg_q.grav_const   <= pwdata;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_HALO_MASS:    prdata = cfg_q.halo_mass;
      REG_SCALE_LENGTH: prdata = cfg_q.scale_length;
      REG_GRAV_CONST:   prdata = cfg_q.grav_const;
      default:          prdata = '0;
    endcase
  end

endmodule

FILE: src/hhg_sqrt_stage.sv
module hhg_sqrt_stage import hhg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  sq_data_t data_i,
  output logic     valid_o,
  output sq_data_t data_o
);

  logic     valid_q;
  sq_data_t data_q, data_d;

  // One result bit: bring down two radicand bits, try subtracting 4*root+1
  always_comb begin
    logic [REM_W+1:0] rem2;
    logic [REM_W+1:0] trial;
    logic             ge;
    rem2  = {data_i.rem, data_i.rad[R2_W-1 -: 2]};
    trial = {2'b00, data_i.root, 2'b01};
    ge    = rem2 >= trial;
    data_d      = data_i;
    data_d.rad  = {data_i.rad[R2_W-3:0], 2'b00};
    data_d.rem  = ge ? REM_W'(rem2 - trial) : rem2[REM_W-1:0];
    data_d.root = {data_i.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: src/hhg_div_stage.sv
module hhg_div_stage import hhg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  dv_data_t data_i,
  output logic     valid_o,
  output dv_data_t data_o
);

  logic     valid_q;
  dv_data_t data_q, data_d;

  // One restoring quotient bit for the three axis lanes and the potential lane
  always_comb begin
    logic [ACC_P_W-1:0] sh;
    logic [DEN_W:0]     hi;
    logic [POT_P_W-1:0] psh;
    logic [S_W:0]       phi;
    data_d = data_i;
    for (int i = 0; i < 3; i++) begin
      sh = {data_i.p[i][ACC_P_W-2:0], 1'b0};
      hi = sh[ACC_P_W-1:Q_W];
      if (hi >= {1'b0, data_i.den}) begin
        hi    = hi - {1'b0, data_i.den};
        sh[0] = 1'b1;
      end
      data_d.p[i] = {hi, sh[Q_W-1:0]};
    end
    psh = {data_i.pp[POT_P_W-2:0], 1'b0};
    phi = psh[POT_P_W-1:Q_W];
    if (phi >= {1'b0, data_i.s}) begin
      phi    = phi - {1'b0, data_i.s};
      psh[0] = 1'b1;
    end
    data_d.pp = {phi, psh[Q_W-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: src/hernquist_halo_gravity_top.sv
// Hernquist halo gravity: one particle per cycle goes in on the s_axis side, and
// its acceleration with the halo term added, the halo potential and a saturation
// flag come out on the m_axis side after passing through the 32-stage square root
// pipeline, the 35-stage divider pipeline and nine stages of input, multiply and
// output registers; a new particle is taken every cycle and the whole pipeline
// holds while the output is stalled. The user must write registers over the APB
// port only while no particle is in flight; the block itself does not enforce it.
module hernquist_halo_gravity_top import hhg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // Particle input
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,  // pos_x, pos_y, pos_z, acc_in_x, acc_in_y, acc_in_z
  // Result output
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // acc_out_x, acc_out_y, acc_out_z, potential
  output logic [0:0]   m_axis_tuser   // saturated
);

  cfg_t              cfg;
  logic [GM_W-1:0]   gm_q;
  logic              en;

  hhg_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // G*M is registered from the configuration registers and follows them in the next cycle
  always_ff @(posedge clk_i) begin
    gm_q <= GM_W'(cfg.grav_const) * GM_W'(cfg.halo_mass);
  end

  // Global advance: move unless a result sits unaccepted
  logic out_valid_q;
  assign en            = m_axis_tready | ~out_valid_q;
  assign s_axis_tready = en;

  // Stage 1: magnitudes and signs
  logic     s1_v_q;
  sq_side_t s1_q, s1_d;
  always_comb begin
    logic signed [DATA_W-1:0] p;
    s1_d = '0;
    for (int i = 0; i < 3; i++) begin
      p              = s_axis_tdata[i*DATA_W +: DATA_W];
      s1_d.acc[i]    = s_axis_tdata[(3+i)*DATA_W +: DATA_W];
      s1_d.mag[i]    = p[DATA_W-1] ? (~p + 1'b1) : p;
      s1_d.pos_neg[i] = p[DATA_W-1];
      s1_d.pos_pos[i] = ~p[DATA_W-1] & (p != '0);
    end
  end

  // Stage 2: squares
  logic                     s2_v_q;
  sq_side_t                 s2_side_q;
  logic [2:0][R2_W-1:0]     s2_sq_q;

  // Stage 3: sum of squares into the square root pipeline
  logic     s3_v_q;
  sq_data_t s3_q;

  // Square root chain
  logic     sq_v [SQ_STAGES+1];
  sq_data_t sq_d [SQ_STAGES+1];
  assign sq_v[0] = s3_v_q;
  assign sq_d[0] = s3_q;

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    hhg_sqrt_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[k]),
      .data_i  (sq_d[k]),
      .valid_o (sq_v[k+1]),
      .data_o  (sq_d[k+1])
    );
  end

  // Stage 4: s = r + a
  logic                   s4_v_q;
  dv_side_t               s4_side_q;
  logic [2:0][DATA_W-1:0] s4_mag_q;
  logic [ROOT_W-1:0]      s4_r_q;
  logic [S_W-1:0]         s4_s_q;

  // Stage 5: s*s
  logic                   s5_v_q;
  dv_side_t               s5_side_q;
  logic [2:0][DATA_W-1:0] s5_mag_q;
  logic [ROOT_W-1:0]      s5_r_q;
  logic [S_W-1:0]         s5_s_q;
  logic [S2_W-1:0]        s5_s2_q;

  // Stage 6: partial products of the denominator and numerators
  logic                   s6_v_q;
  dv_side_t               s6_side_q;
  logic [S_W-1:0]         s6_s_q;
  logic [63:0]            s6_den_lo_q;
  logic [S2_W-1:0]        s6_den_hi_q;
  logic [2:0][63:0]       s6_num_lo_q;
  logic [2:0][63:0]       s6_num_hi_q;

  // Stage 7: full denominator and numerators
  logic                   s7_v_q;
  dv_side_t               s7_side_q;
  logic [S_W-1:0]         s7_s_q;
  logic [DEN_W-1:0]       s7_den_q;
  logic [2:0][NUM_W-1:0]  s7_num_q;

  // Stage 8: range checks and divider load
  logic     s8_v_q;
  dv_data_t s8_q, s8_d;
  always_comb begin
    logic [NUM_W-1:0] nsh;
    s8_d      = '0;
    s8_d.side = s7_side_q;
    s8_d.den  = s7_den_q;
    s8_d.s    = s7_s_q;
    for (int i = 0; i < 3; i++) begin
      nsh              = s7_num_q[i] >> Q_W;
      s8_d.side.ovf[i] = nsh >= NUM_W'(s7_den_q);
      s8_d.p[i]        = ACC_P_W'(s7_num_q[i]);
    end
    s8_d.side.pot_ovf = (gm_q >> Q_W) >= GM_W'(s7_s_q);
    s8_d.pp           = POT_P_W'(gm_q);
  end

  // Divider chain
  logic     dv_v [DIV_STAGES+1];
  dv_data_t dv_d [DIV_STAGES+1];
  assign dv_v[0] = s8_v_q;
  assign dv_d[0] = s8_q;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    hhg_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[k]),
      .data_i  (dv_d[k]),
      .valid_o (dv_v[k+1]),
      .data_o  (dv_d[k+1])
    );
  end

  // Output stage: clamp, apply the term, saturate
  logic [127:0] out_data_q, out_data_d;
  logic         out_sat_q, out_sat_d;
  always_comb begin
    dv_data_t                 f;
    logic [Q_W-1:0]           q;
    logic signed [DATA_W+3:0] sum;
    logic [DATA_W-1:0]        res;
    logic [DATA_W-1:0]        pot;
    f         = dv_d[DIV_STAGES];
    out_sat_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      q = f.p[i][Q_W-1:0];
      if (f.side.ovf[i] || q > ACC_Q_MAX) begin
        q = ACC_Q_MAX;
      end
      sum = {{4{f.side.acc[i][DATA_W-1]}}, f.side.acc[i]};
      if (f.side.pos_pos[i]) begin
        sum = sum - $signed({1'b0, q});
      end else if (f.side.pos_neg[i]) begin
        sum = sum + $signed({1'b0, q});
      end
      res = sum[DATA_W-1:0];
      if (f.side.r_nz && (sum[DATA_W+3:DATA_W-1] != '0) && (sum[DATA_W+3:DATA_W-1] != '1)) begin
        out_sat_d = 1'b1;
        res       = sum[DATA_W+3] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
      out_data_d[i*DATA_W +: DATA_W] = f.side.r_nz ? res : f.side.acc[i];
    end
    q = f.pp[Q_W-1:0];
    if (f.side.s_z) begin
      out_sat_d = 1'b1;
      q         = POT_Q_MAX;
    end else if (f.side.pot_ovf || q > POT_Q_MAX) begin
      out_sat_d = 1'b1;
      q         = POT_Q_MAX;
    end
    pot = ~q[DATA_W-1:0] + 1'b1;
    out_data_d[3*DATA_W +: DATA_W] = pot;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      s5_v_q      <= 1'b0;
      s6_v_q      <= 1'b0;
      s7_v_q      <= 1'b0;
      s8_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_v_q      <= s_axis_tvalid;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      s4_v_q      <= sq_v[SQ_STAGES];
      s5_v_q      <= s4_v_q;
      s6_v_q      <= s5_v_q;
      s7_v_q      <= s6_v_q;
      s8_v_q      <= s7_v_q;
      out_valid_q <= dv_v[DIV_STAGES];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1
      s1_q <= s1_d;
      // stage 2
      s2_side_q <= s1_q;
      for (int i = 0; i < 3; i++) begin
        s2_sq_q[i] <= R2_W'(s1_q.mag[i]) * R2_W'(s1_q.mag[i]);
      end
      // stage 3
      s3_q.rad  <= s2_sq_q[0] + s2_sq_q[1] + s2_sq_q[2];
      s3_q.rem  <= '0;
      s3_q.root <= '0;
      s3_q.side <= s2_side_q;
      // stage 4
      s4_r_q            <= sq_d[SQ_STAGES].root;
      s4_s_q            <= S_W'(sq_d[SQ_STAGES].root) + S_W'(cfg.scale_length);
      s4_mag_q          <= sq_d[SQ_STAGES].side.mag;
      s4_side_q.acc     <= sq_d[SQ_STAGES].side.acc;
      s4_side_q.pos_pos <= sq_d[SQ_STAGES].side.pos_pos;
      s4_side_q.pos_neg <= sq_d[SQ_STAGES].side.pos_neg;
      s4_side_q.r_nz    <= sq_d[SQ_STAGES].root != '0;
      s4_side_q.s_z     <= (sq_d[SQ_STAGES].root == '0) && (cfg.scale_length == '0);
      s4_side_q.ovf     <= '0;
      s4_side_q.pot_ovf <= 1'b0;
      // stage 5
      s5_side_q <= s4_side_q;
      s5_mag_q  <= s4_mag_q;
      s5_r_q    <= s4_r_q;
      s5_s_q    <= s4_s_q;
      s5_s2_q   <= S2_W'(s4_s_q) * S2_W'(s4_s_q);
      // stage 6
      s6_side_q   <= s5_side_q;
      s6_s_q      <= s5_s_q;
      s6_den_lo_q <= 64'(s5_s2_q[31:0]) * 64'(s5_r_q);
      s6_den_hi_q <= S2_W'(s5_s2_q[S2_W-1:32]) * S2_W'(s5_r_q);
      for (int i = 0; i < 3; i++) begin
        s6_num_lo_q[i] <= 64'(gm_q[31:0]) * 64'(s5_mag_q[i]);
        s6_num_hi_q[i] <= 64'(gm_q[GM_W-1:32]) * 64'(s5_mag_q[i]);
      end
      // stage 7
      s7_side_q <= s6_side_q;
      s7_s_q    <= s6_s_q;
      s7_den_q  <= (DEN_W'(s6_den_hi_q) << 32) + DEN_W'(s6_den_lo_q);
      for (int i = 0; i < 3; i++) begin
        s7_num_q[i] <= NUM_W'((PROD_W'(s6_num_hi_q[i]) << 32) + PROD_W'(s6_num_lo_q[i]))
                       << FRAC_BITS;
      end
      // stage 8
      s8_q <= s8_d;
      // output
      out_data_q <= out_data_d;
      out_sat_q  <= out_sat_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;

endmodule
